// ===== hw/rtl/wsfr_pkg.sv =====
// Shared types and constants for the WebSocket fragment reassembler.
package wsfr_pkg;

  // Operation codes of an input item
  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_DATA   = 1'b1;

  // Frame opcodes
  localparam logic [3:0] OPC_CONT   = 4'h0;
  localparam logic [3:0] OPC_TEXT   = 4'h1;
  localparam logic [3:0] OPC_BINARY = 4'h2;

  // Register indexes, decoded from paddr[2]
  localparam logic REG_MODE    = 1'b0;
  localparam logic REG_MAX_MSG = 1'b1;

  localparam logic [15:0] MAX_MSG_RESET = 16'd4096;

  typedef enum logic [1:0] {
    ST_PENDING    = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_COMPLETE   = 2'd2,
    ST_ERROR      = 2'd3
  } status_t;

  typedef struct packed {
    logic        operation;
    logic [3:0]  opcode;
    logic        fin;
    logic [15:0] frame_length;
    logic [15:0] chunk_offset;
    logic [15:0] chunk_length;
    logic [7:0]  byte_value;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic        byte_valid;
    logic [15:0] byte_index;
    logic [7:0]  out_byte;
    logic [15:0] total_length;
  } out_item_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] max_message_bytes;
  } cfg_t;

endpackage

// ===== hw/rtl/wsfr_cfg_regs.sv =====
// APB-style configuration registers: mode and maximum message size.
module wsfr_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output wsfr_pkg::cfg_t      cfg
);
  import wsfr_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode              <= 1'b0;
      cfg.max_message_bytes <= MAX_MSG_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MODE:    cfg.mode              <= pwdata[0];
        REG_MAX_MSG: cfg.max_message_bytes <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE:    prdata = {31'd0, cfg.mode};
      REG_MAX_MSG: prdata = {16'd0, cfg.max_message_bytes};
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/wsfr_core.sv =====
// Reassembly state and the per-item check and update logic.
module wsfr_core #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wsfr_pkg::cfg_t       cfg,
  input  logic                 accept,
  input  wsfr_pkg::in_item_t   item,
  output wsfr_pkg::out_item_t  res
);
  import wsfr_pkg::*;

  localparam int L = LENGTH_BITS;

  typedef struct packed {
    logic         assembling;
    logic         awaiting_continuation;
    logic [L-1:0] bytes_received;
    logic [L-1:0] current_frame_length;
    logic [L-1:0] current_frame_offset;
    logic [L-1:0] chunk_bytes_left;
    logic         chunk_final;
  } state_t;

  state_t       st;
  state_t       st_next;
  logic [3:0]   start_opc;
  logic [L-1:0] maxb;
  logic [L-1:0] plen;
  logic [L-1:0] poff;
  logic [L-1:0] clen;
  logic [L-1:0] norm;
  logic         err;
  logic         end_of_chunk;

  always_comb begin
    st_next      = st;
    res          = '0;
    res.status   = ST_PENDING;
    err          = 1'b0;
    end_of_chunk = 1'b0;
    start_opc    = cfg.mode ? OPC_BINARY : OPC_TEXT;
    maxb         = L'(cfg.max_message_bytes);
    plen         = L'(item.frame_length);
    poff         = L'(item.chunk_offset);
    clen         = L'(item.chunk_length);
    norm         = (plen == '0) ? clen : plen;

    if (item.operation == OP_HEADER) begin
      if (st.chunk_bytes_left != '0 ||
          (item.opcode != start_opc && item.opcode != OPC_CONT)) err = 1'b1;
      if (cfg.mode && (norm == '0 || norm > maxb)) err = 1'b1;
      // a too-large offset already fails, so the difference cannot wrap when it matters
      if (norm < clen || poff > norm || clen > norm - poff) err = 1'b1;
      if (poff == '0) begin
        if (item.opcode == start_opc) begin
          if (st.assembling) err = 1'b1;
          st_next.assembling            = 1'b1;
          st_next.bytes_received        = '0;
          st_next.awaiting_continuation = 1'b0;
        end else if (!st.assembling || !st.awaiting_continuation) begin
          err = 1'b1;
        end
        st_next.current_frame_length = norm;
        st_next.current_frame_offset = '0;
      end else if (!st.assembling || poff != st.current_frame_offset ||
                   norm != st.current_frame_length) begin
        err = 1'b1;
      end
      if (st_next.bytes_received > maxb || clen > maxb - st_next.bytes_received) err = 1'b1;
      st_next.chunk_final      = item.fin;
      st_next.chunk_bytes_left = clen;
      end_of_chunk             = (clen == '0);
    end else begin
      if (st.chunk_bytes_left == '0) begin
        err = 1'b1;
      end else begin
        st_next.bytes_received       = st.bytes_received + L'(1);
        st_next.current_frame_offset = st.current_frame_offset + L'(1);
        st_next.chunk_bytes_left     = st.chunk_bytes_left - L'(1);
        res.byte_valid               = 1'b1;
        res.byte_index               = 16'(st.bytes_received);
        res.out_byte                 = item.byte_value;
        end_of_chunk                 = (st.chunk_bytes_left == L'(1));
      end
    end

    // chunk done: decide frame and message end on the updated counters
    if (end_of_chunk && !err) begin
      if (st_next.current_frame_offset < st_next.current_frame_length) begin
        res.status = ST_INCOMPLETE;
      end else if (st_next.current_frame_offset != st_next.current_frame_length) begin
        // keep the byte of a data transaction, clear the state
        st_next    = '0;
        res.status = ST_ERROR;
      end else if (!st_next.chunk_final) begin
        st_next.awaiting_continuation = 1'b1;
        st_next.current_frame_length  = '0;
        st_next.current_frame_offset  = '0;
        res.status                    = ST_INCOMPLETE;
      end else begin
        res.status       = ST_COMPLETE;
        res.total_length = 16'(st_next.bytes_received);
        st_next          = '0;
      end
    end

    if (err) begin
      st_next    = '0;
      res        = '0;
      res.status = ST_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule

// ===== hw/rtl/wsfr_out_buf.sv =====
// Result register with a skid stage, decoupling the result side from the item side.
module wsfr_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  wsfr_pkg::out_item_t  push_data,
  output logic                 full,
  output logic                 result_valid,
  output wsfr_pkg::out_item_t  result,
  input  logic                 result_stall
);
  import wsfr_pkg::*;

  out_item_t skid;
  logic      skid_valid;
  logic      pop;
  logic      to_main;

  assign full    = skid_valid;
  assign pop     = result_valid && !result_stall;
  assign to_main = !result_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (push) begin
      // skid is empty whenever a transaction is taken
      if (to_main) result_valid <= 1'b1;
      else         skid_valid   <= 1'b1;
    end else if (pop) begin
      result_valid <= skid_valid;
      skid_valid   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (to_main) result <= push_data;
      else         skid   <= push_data;
    end else if (pop) begin
      result <= skid;
    end
  end

endmodule

// ===== hw/rtl/ws_fragment_reassembler_top.sv =====
// Top level of the WebSocket fragment reassembler.
//
// Takes chunk headers and data bytes and returns one result per item: status, the
// accepted byte with its message index for an external store, and the message
// length on completion. All checks and counter updates for an item are done in
// the cycle it is accepted, against the reassembly state registers, so sustained
// throughput is one item per cycle while item_stall is low. Results sit in an
// output register backed by a one-entry skid stage; item_stall rises only when
// both hold a result that the result side has not yet taken. Any rule violation
// returns status error and clears the reassembly state. Configuration (mode at
// 0x0, max_message_bytes at 0x4) is written over the APB port with no wait
// states; the user must write it only while no item is in flight (not enforced).
module ws_fragment_reassembler_top #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  wsfr_pkg::in_item_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output wsfr_pkg::out_item_t  result
);
  import wsfr_pkg::*;

  cfg_t      cfg;
  out_item_t core_res;
  logic      accept;

  assign accept = item_valid && !item_stall;

  wsfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wsfr_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .item   (item),
    .res    (core_res)
  );

  wsfr_out_buf u_out (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .push_data    (core_res),
    .full         (item_stall),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

endmodule
